@@ hdl/oct_pkg.sv @@
// shared widths, constants and the divider chain item type for the octahedral encoder
package oct_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int CODE_BITS      = 8;

    // |c| of the most negative component still fits in COMPONENT_BITS unsigned
    localparam int MAG_W = COMPONENT_BITS;
    // sum of three magnitudes stays below 2^(COMPONENT_BITS+1)
    localparam int SUM_W = COMPONENT_BITS + 1;
    // divisor 2s and dividend base t, both in [0, 2s]
    localparam int DEN_W = COMPONENT_BITS + 2;
    // dividend CODE_MAX * t
    localparam int NUM_W = DEN_W + CODE_BITS;
    // divisor aligned to the top quotient bit
    localparam int DIV_W = DEN_W + CODE_BITS - 1;

    localparam int IN_TDATA_W  = ((3 * COMPONENT_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * CODE_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 1;

    localparam logic [CODE_BITS-1:0] CODE_MAX  = {CODE_BITS{1'b1}};
    localparam logic [CODE_BITS-1:0] CODE_HALF = CODE_MAX >> 1;

    typedef struct packed {
        logic [NUM_W-1:0]     rem_u;
        logic [NUM_W-1:0]     rem_v;
        logic [DIV_W-1:0]     den;
        logic [CODE_BITS-1:0] quo_u;
        logic [CODE_BITS-1:0] quo_v;
        logic                 zero;
    } oct_div_t;

endpackage

@@ hdl/oct_front.sv @@
// front pipeline: magnitudes, octahedral sum, fold select and dividend setup
module oct_front import oct_pkg::*; (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COMPONENT_BITS-1:0] norm_x,
    input  logic signed [COMPONENT_BITS-1:0] norm_y,
    input  logic signed [COMPONENT_BITS-1:0] norm_z,
    output logic                             out_valid,
    input  logic                             out_ready,
    output oct_div_t                         out_data
);

    // stage 1: magnitudes and signs
    logic             vld1_reg;
    logic [MAG_W-1:0] ax1_reg, ay1_reg, az1_reg;
    logic             sx1_reg, sy1_reg, sz1_reg;
    // stage 2: sum
    logic             vld2_reg;
    logic [MAG_W-1:0] ax2_reg, ay2_reg;
    logic [SUM_W-1:0] s2_reg, s2_next;
    logic             sx2_reg, sy2_reg, sz2_reg;
    // stage 3: folded dividends
    logic             vld3_reg;
    logic [DEN_W-1:0] tu3_reg, tv3_reg, d3_reg;
    logic [DEN_W-1:0] tu3_next, tv3_next, s_ext, s_dbl;
    logic             zero3_reg;
    // stage 4: scaled dividend and aligned divisor
    logic             vld4_reg;
    oct_div_t         data4_reg, data4_next;

    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !vld4_reg || out_ready;
    assign rdy3     = !vld3_reg || rdy4;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    assign s2_next = SUM_W'(ax1_reg) + SUM_W'(ay1_reg) + SUM_W'(az1_reg);

    always_comb begin
        s_ext = DEN_W'(s2_reg);
        s_dbl = {s2_reg, 1'b0};
        if (!sz2_reg) begin
            // upper half: c + s with c = x or y
            tu3_next = sx2_reg ? s_ext - DEN_W'(ax2_reg) : s_ext + DEN_W'(ax2_reg);
            tv3_next = sy2_reg ? s_ext - DEN_W'(ay2_reg) : s_ext + DEN_W'(ay2_reg);
        end else begin
            // lower half folded outward
            tu3_next = sx2_reg ? DEN_W'(ay2_reg) : s_dbl - DEN_W'(ay2_reg);
            tv3_next = sy2_reg ? DEN_W'(ax2_reg) : s_dbl - DEN_W'(ax2_reg);
        end
    end

    always_comb begin
        data4_next.rem_u = (NUM_W'(tu3_reg) << CODE_BITS) - NUM_W'(tu3_reg);
        data4_next.rem_v = (NUM_W'(tv3_reg) << CODE_BITS) - NUM_W'(tv3_reg);
        data4_next.den   = DIV_W'(d3_reg) << (CODE_BITS - 1);
        data4_next.quo_u = '0;
        data4_next.quo_v = '0;
        data4_next.zero  = zero3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= in_valid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
            if (rdy4) vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            ax1_reg <= norm_x[COMPONENT_BITS-1] ? MAG_W'(-norm_x) : MAG_W'(norm_x);
            ay1_reg <= norm_y[COMPONENT_BITS-1] ? MAG_W'(-norm_y) : MAG_W'(norm_y);
            az1_reg <= norm_z[COMPONENT_BITS-1] ? MAG_W'(-norm_z) : MAG_W'(norm_z);
            sx1_reg <= norm_x[COMPONENT_BITS-1];
            sy1_reg <= norm_y[COMPONENT_BITS-1];
            sz1_reg <= norm_z[COMPONENT_BITS-1];
        end
        if (rdy2 && vld1_reg) begin
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            s2_reg  <= s2_next;
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;
            sz2_reg <= sz1_reg;
        end
        if (rdy3 && vld2_reg) begin
            tu3_reg   <= tu3_next;
            tv3_reg   <= tv3_next;
            d3_reg    <= s_dbl;
            zero3_reg <= (s2_reg == '0);
        end
        if (rdy4 && vld3_reg) begin
            data4_reg <= data4_next;
        end
    end

    assign out_valid = vld4_reg;
    assign out_data  = data4_reg;

endmodule

@@ hdl/oct_div_cell.sv @@
// one restoring divider cell: resolves one quotient bit for both coordinates
module oct_div_cell import oct_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  oct_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output oct_div_t out_data
);

    logic             vld_reg;
    oct_div_t         data_reg, data_next;
    logic [NUM_W-1:0] den_ext;
    logic             ge_u, ge_v;

    always_comb begin
        den_ext = NUM_W'(in_data.den);
        ge_u    = in_data.rem_u >= den_ext;
        ge_v    = in_data.rem_v >= den_ext;

        data_next       = in_data;
        data_next.rem_u = ge_u ? in_data.rem_u - den_ext : in_data.rem_u;
        data_next.rem_v = ge_v ? in_data.rem_v - den_ext : in_data.rem_v;
        data_next.quo_u = {in_data.quo_u[CODE_BITS-2:0], ge_u};
        data_next.quo_v = {in_data.quo_v[CODE_BITS-2:0], ge_v};
        // divisor moves down to the next quotient bit
        data_next.den   = in_data.den >> 1;
    end

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/octahedral_normal_encoder_unit.sv @@
// top level of the octahedral normal encoder: front pipeline, divider cell row, output register
//
// usage:
//   s_ channel carries one normal per item, three signed Q1.15 components
//   m_ channel returns one item per input: two unsigned code bytes and a zero flag
//   the flag is set for an all-zero vector, whose codes then read as half scale
// pipeline from input accept to m_tvalid: 4 front stages, one
//   divider cell per code bit, one output register
// throughput: one item per cycle while the output is not stalled; every stage is a register with its own
//   valid bit, so there is no shared unit and no loop-back to wait on
// stall: each stage takes a new item when it is empty or its successor moves,
//   so bubbles close up and s_tready stays high until every stage holds an
//   item behind a stalled output
// reset: aresetn low clears all valid bits; nothing is in flight afterward
//   and no item is emitted until new input arrives
module octahedral_normal_encoder_unit import oct_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // norm_x, norm_y, norm_z
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // enc_u, enc_v
    output logic [OUT_TUSER_W-1:0] m_tuser    // zero_input
);

    // chain links: index 0 is the front output, index CODE_BITS the last cell
    logic     link_valid [CODE_BITS+1];
    logic     link_ready [CODE_BITS+1];
    oct_div_t link_data  [CODE_BITS+1];

    logic                 out_vld_reg;
    logic [CODE_BITS-1:0] enc_u_reg, enc_v_reg;
    logic                 zero_reg;
    logic                 out_take;

    // magnitudes, sum, fold and dividend setup
    oct_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .norm_x    (s_tdata[COMPONENT_BITS-1:0]),
        .norm_y    (s_tdata[2*COMPONENT_BITS-1:COMPONENT_BITS]),
        .norm_z    (s_tdata[3*COMPONENT_BITS-1:2*COMPONENT_BITS]),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // one cell per code bit, most significant bit first
    for (genvar i = 0; i < CODE_BITS; i++) begin : g_cell
        oct_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    // output register parts the cell row from the receiver
    assign link_ready[CODE_BITS] = !out_vld_reg || m_tready;
    assign out_take              = link_ready[CODE_BITS] && link_valid[CODE_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (link_ready[CODE_BITS]) begin
            out_vld_reg <= link_valid[CODE_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            // zero vector has no direction: report half scale on both codes
            enc_u_reg <= link_data[CODE_BITS].zero ? CODE_HALF : link_data[CODE_BITS].quo_u;
            enc_v_reg <= link_data[CODE_BITS].zero ? CODE_HALF : link_data[CODE_BITS].quo_v;
            zero_reg  <= link_data[CODE_BITS].zero;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_TDATA_W'({enc_v_reg, enc_u_reg});
    assign m_tuser  = OUT_TUSER_W'(zero_reg);

`ifndef SYNTH
    // flagged items always carry the half-scale codes
    a_zero_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[CODE_BITS-1:0] == CODE_HALF &&
             m_tdata[2*CODE_BITS-1:CODE_BITS] == CODE_HALF))
        else $error("zero item without half-scale codes");

    // with the output register empty the whole chain must be able to move
    a_ready_ripple: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register is empty");

    // reset leaves nothing in flight
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

@@ test/tb_octahedral_normal_encoder_unit.sv @@
// self-checking stream testbench for the octahedral normal encoder
module tb_octahedral_normal_encoder_unit;
    import oct_pkg::*;

    localparam int RANDOM_NORMALS  = 750;
    localparam int QUIET_TAIL      = 120;   // last random items run with no idling
    localparam int DRAIN_CYCLES    = 40;    // extra wait after the drain, well beyond the pipeline depth
    localparam int MAX_REPORTS     = 40;

    typedef logic signed [COMPONENT_BITS-1:0] comp_t;

    typedef struct {
        comp_t                nx;
        comp_t                ny;
        comp_t                nz;
        logic [CODE_BITS-1:0] enc_u;
        logic [CODE_BITS-1:0] enc_v;
        logic                 zero_input;
    } octa_code_t;

    // holds predicted codes for accepted normals, compares returned items in order
    class octa_code_checker;
        octa_code_t expected_codes[$];
        int         mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // exact integer octahedral projection, floor of CODE_MAX*t/(2s) with t = c+s in the upper half
        function octa_code_t predict_octa_code(comp_t x, comp_t y, comp_t z);
            octa_code_t p;
            longint     sx, sy, sz, ax, ay, az, sum, tu, tv, full;
            sx = x;
            sy = y;
            sz = z;
            ax = (sx < 0) ? -sx : sx;
            ay = (sy < 0) ? -sy : sy;
            az = (sz < 0) ? -sz : sz;
            sum = ax + ay + az;
            full = longint'(CODE_MAX);
            p.nx = x;
            p.ny = y;
            p.nz = z;
            if (sum == 0) begin
                // undefined direction: half scale codes and the flag
                p.enc_u      = CODE_HALF;
                p.enc_v      = CODE_HALF;
                p.zero_input = 1'b1;
                return p;
            end
            if (sz >= 0) begin
                tu = sx + sum;
                tv = sy + sum;
            end else begin
                // lower hemisphere folds outward, zero counts as positive
                tu = (sx >= 0) ? (2 * sum - ay) : ay;
                tv = (sy >= 0) ? (2 * sum - ax) : ax;
            end
            p.enc_u      = CODE_BITS'((full * tu) / (2 * sum));
            p.enc_v      = CODE_BITS'((full * tv) / (2 * sum));
            p.zero_input = 1'b0;
            return p;
        endfunction

        function void note_normal(comp_t x, comp_t y, comp_t z);
            expected_codes = {expected_codes, predict_octa_code(x, y, z)};
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_code(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
            octa_code_t           e;
            logic [CODE_BITS-1:0] got_u, got_v;
            logic                 got_zero;
            got_u    = tdata[CODE_BITS-1:0];
            got_v    = tdata[2*CODE_BITS-1:CODE_BITS];
            got_zero = tuser[0];
            if (expected_codes.size() == 0) begin
                report_mismatch($sformatf("unexpected item u=%0d v=%0d zero=%0b",
                                          got_u, got_v, got_zero));
                return;
            end
            e = expected_codes.pop_front();
            if (got_u !== e.enc_u)
                report_mismatch($sformatf("enc_u %0d, want %0d for (%0d,%0d,%0d)",
                                          got_u, e.enc_u, e.nx, e.ny, e.nz));
            if (got_v !== e.enc_v)
                report_mismatch($sformatf("enc_v %0d, want %0d for (%0d,%0d,%0d)",
                                          got_v, e.enc_v, e.nx, e.ny, e.nz));
            if (got_zero !== e.zero_input)
                report_mismatch($sformatf("zero_input %0b, want %0b for (%0d,%0d,%0d)",
                                          got_zero, e.zero_input, e.nx, e.ny, e.nz));
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // norm_x, norm_y, norm_z
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // enc_u, enc_v
    logic [OUT_TUSER_W-1:0] m_tuser;    // zero_input

    octa_code_checker code_checker;
    bit               quiet_phase;

    octahedral_normal_encoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // present one normal and hold it until accepted
    task automatic send_normal(input comp_t x, input comp_t y, input comp_t z);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({z, y, x});
        do @(posedge aclk); while (!s_tready);
        code_checker.note_normal(x, y, z);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_for_drain();
        while (code_checker.pending() != 0) @(posedge aclk);
    endtask

    function automatic comp_t pick_component(input int kind);
        case (kind)
            0:       return comp_t'($urandom);
            1:       return comp_t'($urandom_range(0, 40)) - comp_t'(20);
            2:       return ($urandom_range(0, 1) != 0) ? comp_t'(-32768 + $urandom_range(0, 8))
                                                        : comp_t'(32767 - $urandom_range(0, 8));
            default: return '0;
        endcase
    endfunction

    // mix of full-range, tiny, near-axis, sparse and zero vectors
    task automatic send_random_normal();
        int    shape;
        comp_t c[3];
        shape = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            if (shape < 40)
                c[i] = pick_component(0);
            else if (shape < 65)
                c[i] = pick_component(1);
            else if (shape < 80)
                c[i] = pick_component((i == $urandom_range(0, 2)) ? 2 : 1);
            else if (shape < 95)
                c[i] = ($urandom_range(0, 1) != 0) ? pick_component(0) : comp_t'(0);
            else
                c[i] = '0;
        end
        send_normal(c[0], c[1], c[2]);
    endtask

    // result side: random stall bursts, none once the quiet tail starts
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (quiet_phase) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // sample returned items at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            code_checker.check_code(m_tdata, m_tuser);
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        code_checker = new();
        quiet_phase  = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero vector, axis extremes, most negative components,
        // folding with zero components, full-scale and tiny sums
        send_normal(16'sd0, 16'sd0, 16'sd0);
        send_normal(16'sd32767, 16'sd0, 16'sd0);
        send_normal(-16'sd32768, 16'sd0, 16'sd0);
        send_normal(16'sd0, 16'sd32767, 16'sd0);
        send_normal(16'sd0, -16'sd32768, 16'sd0);
        send_normal(16'sd0, 16'sd0, 16'sd32767);
        send_normal(16'sd0, 16'sd0, -16'sd32768);
        send_normal(-16'sd32768, -16'sd32768, -16'sd32768);
        send_normal(16'sd32767, 16'sd32767, 16'sd32767);
        send_normal(-16'sd32768, 16'sd32767, -16'sd1);
        send_normal(16'sd32767, -16'sd32768, -16'sd32768);
        send_normal(16'sd0, 16'sd0, -16'sd1);
        send_normal(16'sd0, -16'sd5, -16'sd7);
        send_normal(-16'sd5, 16'sd0, -16'sd7);
        send_normal(-16'sd3, -16'sd4, 16'sd0);
        send_normal(16'sd1, 16'sd0, 16'sd0);
        send_normal(-16'sd1, 16'sd0, 16'sd0);
        send_normal(16'sd1, 16'sd1, 16'sd1);
        send_normal(16'sd1, -16'sd1, -16'sd1);
        send_normal(16'sd23170, 16'sd23170, 16'sd0);
        send_normal(-16'sd18918, 16'sd18918, -16'sd18918);
        send_normal(16'sd0, 16'sd0, 16'sd1);

        // hold off until the pipeline has emptied completely
        pause_sender(1);
        wait_for_drain();

        for (int n = 0; n < RANDOM_NORMALS; n++) begin
            if (n == RANDOM_NORMALS / 2) begin
                pause_sender(1);
                wait_for_drain();
            end
            if (n == RANDOM_NORMALS - QUIET_TAIL)
                quiet_phase = 1'b1;
            if (!quiet_phase && $urandom_range(0, 5) == 0)
                pause_sender($urandom_range(1, 10));
            send_random_normal();
        end

        pause_sender(1);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (code_checker.mismatch_count == 0 && code_checker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
